/* src/dtq_pkg.sv */
// Shared types, codes and sizes for the deadline timer queue.
package dtq_pkg;

  localparam int TIME_W = 48;
  localparam int ID_W = 8;
  localparam int CAPACITY_DEF = 32;

  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

  // Operation codes.
  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_CANCEL = 2'd1;
  localparam logic [1:0] OP_TICK = 2'd2;
  localparam logic [1:0] OP_SHUTDOWN = 2'd3;

  // Result kinds.
  localparam logic [2:0] KIND_INSERT = 3'd0;
  localparam logic [2:0] KIND_CANCEL = 3'd1;
  localparam logic [2:0] KIND_EXPIRED = 3'd2;
  localparam logic [2:0] KIND_IDLE_TICK = 3'd3;
  localparam logic [2:0] KIND_SHUTDOWN = 3'd4;

  // Status codes.
  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_STOPPED = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;
  localparam logic [1:0] ST_NOT_FOUND = 2'd3;

  // Timer re-arm actions.
  localparam logic [1:0] ARM_LEAVE = 2'd0;
  localparam logic [1:0] ARM_SET = 2'd1;
  localparam logic [1:0] ARM_CLEAR = 2'd2;

  // One stored timer.
  typedef struct packed {
    logic [TIME_W-1:0] deadline;
    logic [ID_W-1:0] ident;
  } entry_t;

  // Results of the shared time unit.
  typedef struct packed {
    logic [TIME_W-1:0] sum_sat;
    logic a_le_b;
    logic [TIME_W-1:0] gap;
  } alu_res_t;

endpackage

/* src/dtq_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module dtq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* src/dtq_alu.sv */
// Shared time unit: saturating add, ordered compare and re-arm gap.
module dtq_alu
  import dtq_pkg::*;
(
  input  logic [TIME_W-1:0] a,
  input  logic [TIME_W-1:0] b,
  output alu_res_t          res
);

  logic [TIME_W:0] sum;
  logic [TIME_W-1:0] diff;

  // One adder serves the deadline sum, the subtractor the compare and gap.
  always_comb begin
    sum = {1'b0, a} + {1'b0, b};
    diff = a - b;
    res.sum_sat = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
    res.a_le_b = (a <= b);
    res.gap = (a > b) ? diff : TIME_W'(1);
  end

endmodule

/* src/deadline_timer_queue.sv */
// Top level of the deadline timer queue: sequencer, sorted store and time unit.
//
//  channel  | ports                                         | flow
//  ---------+-----------------------------------------------+--------------------------
//  input    | start, busy, in_op, in_entry_id, in_duration, | taken when start & !busy
//           | in_now                                        |
//  result   | out_valid, out_kind, out_entry_id_out, ...    | one-cycle strobe, no stall
//
// Shutdown and refused inserts are answered straight from idle. Insert compares
// stored entries one at a time; cancel searches entries and then shifts later
// ones down one at a time; tick tests entries, sends a word per expired entry
// and moves the survivors down. The single store read port serialises these
// steps. Reset clears occupancy, the arming record and the stopped flag; the
// store itself holds no valid data until written. Results cannot be stalled.
module deadline_timer_queue
  import dtq_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        in_op,
  input  logic [ID_W-1:0]   in_entry_id,
  input  logic [TIME_W-1:0] in_duration,
  input  logic [TIME_W-1:0] in_now,
  output logic              out_valid,
  output logic [2:0]        out_kind,
  output logic [ID_W-1:0]   out_entry_id_out,
  output logic [1:0]        out_status,
  output logic              out_last,
  output logic [1:0]        out_arm_action,
  output logic [TIME_W-1:0] out_arm_duration,
  output logic [5:0]        out_pending_count
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int EW = $bits(entry_t);

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_INS_ADD = 5'd1;
  localparam logic [4:0] S_INS_RD = 5'd2;
  localparam logic [4:0] S_INS_CHK = 5'd3;
  localparam logic [4:0] S_INS_PUT = 5'd4;
  localparam logic [4:0] S_CAN_RD = 5'd5;
  localparam logic [4:0] S_CAN_CHK = 5'd6;
  localparam logic [4:0] S_CAN_SRD = 5'd7;
  localparam logic [4:0] S_CAN_SWR = 5'd8;
  localparam logic [4:0] S_TCK_RD = 5'd9;
  localparam logic [4:0] S_TCK_CHK = 5'd10;
  localparam logic [4:0] S_RA_RD = 5'd11;
  localparam logic [4:0] S_RA_CHK = 5'd12;
  localparam logic [4:0] S_OUT = 5'd13;
  localparam logic [4:0] S_EM_RD = 5'd14;
  localparam logic [4:0] S_EM_OUT = 5'd15;
  localparam logic [4:0] S_CMP_RD = 5'd16;
  localparam logic [4:0] S_CMP_WR = 5'd17;

  logic [4:0] state_r, state_nxt;
  logic [CW-1:0] occ_r, occ_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [CW-1:0] base_r, base_nxt;
  logic armed_r, armed_nxt;
  logic [TIME_W-1:0] armed_dl_r, armed_dl_nxt;
  logic stopped_r, stopped_nxt;
  logic [1:0] op_r, op_nxt;
  logic [ID_W-1:0] id_r, id_nxt;
  logic [TIME_W-1:0] dur_in_r, dur_in_nxt;
  logic [TIME_W-1:0] now_r, now_nxt;
  logic [TIME_W-1:0] dl_r, dl_nxt;
  logic [1:0] st_r, st_nxt;
  logic [1:0] act_r, act_nxt;
  logic [TIME_W-1:0] gap_r, gap_nxt;

  logic ov_r, ov_nxt;
  logic [2:0] ok_r, ok_nxt;
  logic [ID_W-1:0] oid_r, oid_nxt;
  logic [1:0] ost_r, ost_nxt;
  logic olast_r, olast_nxt;
  logic [1:0] oact_r, oact_nxt;
  logic [TIME_W-1:0] odur_r, odur_nxt;
  logic [CW-1:0] ocnt_r, ocnt_nxt;

  logic we;
  logic [AW-1:0] waddr, raddr;
  entry_t wdata, rdata;
  logic [EW-1:0] rdata_raw;
  logic [TIME_W-1:0] alu_a, alu_b;
  alu_res_t alu;
  logic [CW:0] idx_inc, sum_ib;
  logic [CW-1:0] remain;

  assign rdata = entry_t'(rdata_raw);

  dtq_ram #(.WIDTH(EW), .DEPTH(CAPACITY)) u_store (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .raddr(raddr), .rdata(rdata_raw)
  );

  dtq_alu u_alu (.a(alu_a), .b(alu_b), .res(alu));

  assign idx_inc = {1'b0, idx_r} + (CW+1)'(1);
  assign sum_ib = {1'b0, idx_r} + {1'b0, base_r};
  assign remain = occ_r - base_r;
  assign busy = (state_r != S_IDLE);

  // Operand selection for the shared time unit.
  always_comb begin
    alu_a = rdata.deadline;
    alu_b = now_r;
    unique case (state_r)
      S_INS_ADD: begin
        alu_a = now_r;
        alu_b = dur_in_r;
      end
      S_INS_CHK: alu_b = dl_r;
      default: alu_b = now_r;
    endcase
  end

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    occ_nxt = occ_r;
    idx_nxt = idx_r;
    base_nxt = base_r;
    armed_nxt = armed_r;
    armed_dl_nxt = armed_dl_r;
    stopped_nxt = stopped_r;
    op_nxt = op_r;
    id_nxt = id_r;
    dur_in_nxt = dur_in_r;
    now_nxt = now_r;
    dl_nxt = dl_r;
    st_nxt = st_r;
    act_nxt = act_r;
    gap_nxt = gap_r;
    ov_nxt = 1'b0;
    ok_nxt = ok_r;
    oid_nxt = oid_r;
    ost_nxt = ost_r;
    olast_nxt = olast_r;
    oact_nxt = oact_r;
    odur_nxt = odur_r;
    ocnt_nxt = ocnt_r;
    we = 1'b0;
    waddr = idx_r[AW-1:0];
    wdata = rdata;
    raddr = idx_r[AW-1:0];

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          op_nxt = in_op;
          id_nxt = in_entry_id;
          dur_in_nxt = in_duration;
          now_nxt = in_now;
          st_nxt = ST_OK;
          act_nxt = ARM_LEAVE;
          gap_nxt = '0;
          base_nxt = '0;
          idx_nxt = '0;
          unique case (in_op)
            OP_INSERT: begin
              if (stopped_r || (occ_r >= CW'(CAPACITY))) begin
                ov_nxt = 1'b1;
                ok_nxt = KIND_INSERT;
                oid_nxt = in_entry_id;
                ost_nxt = stopped_r ? ST_STOPPED : ST_FULL;
                olast_nxt = 1'b1;
                oact_nxt = ARM_LEAVE;
                odur_nxt = '0;
                ocnt_nxt = occ_r;
              end else begin
                idx_nxt = occ_r;
                state_nxt = S_INS_ADD;
              end
            end
            OP_CANCEL: state_nxt = S_CAN_RD;
            OP_TICK: begin
              armed_nxt = 1'b0;
              state_nxt = S_TCK_RD;
            end
            default: begin
              ov_nxt = 1'b1;
              ok_nxt = KIND_SHUTDOWN;
              oid_nxt = '0;
              ost_nxt = ST_OK;
              olast_nxt = 1'b1;
              oact_nxt = armed_r ? ARM_CLEAR : ARM_LEAVE;
              odur_nxt = '0;
              ocnt_nxt = '0;
              occ_nxt = '0;
              stopped_nxt = 1'b1;
              armed_nxt = 1'b0;
            end
          endcase
        end
      end

      // Insert: shift later entries up one place until the slot is found.
      S_INS_ADD: begin
        dl_nxt = alu.sum_sat;
        state_nxt = (idx_r == '0) ? S_INS_PUT : S_INS_RD;
      end
      S_INS_RD: begin
        raddr = AW'(idx_r - CW'(1));
        state_nxt = S_INS_CHK;
      end
      S_INS_CHK: begin
        if (alu.a_le_b) begin
          state_nxt = S_INS_PUT;
        end else begin
          we = 1'b1;
          idx_nxt = idx_r - CW'(1);
          state_nxt = (idx_r == CW'(1)) ? S_INS_PUT : S_INS_RD;
        end
      end
      S_INS_PUT: begin
        we = 1'b1;
        wdata.deadline = dl_r;
        wdata.ident = id_r;
        occ_nxt = occ_r + CW'(1);
        state_nxt = S_RA_RD;
      end

      // Cancel: search by id, then close the gap.
      S_CAN_RD: begin
        if (idx_r == occ_r) begin
          st_nxt = ST_NOT_FOUND;
          state_nxt = S_OUT;
        end else begin
          state_nxt = S_CAN_CHK;
        end
      end
      S_CAN_CHK: begin
        if (rdata.ident == id_r) begin
          state_nxt = S_CAN_SRD;
        end else begin
          idx_nxt = idx_inc[CW-1:0];
          state_nxt = S_CAN_RD;
        end
      end
      S_CAN_SRD: begin
        raddr = AW'(idx_inc[CW-1:0]);
        if (idx_inc >= {1'b0, occ_r}) begin
          occ_nxt = occ_r - CW'(1);
          state_nxt = S_RA_RD;
        end else begin
          state_nxt = S_CAN_SWR;
        end
      end
      S_CAN_SWR: begin
        we = 1'b1;
        idx_nxt = idx_inc[CW-1:0];
        state_nxt = S_CAN_SRD;
      end

      // Tick: count the expired prefix.
      S_TCK_RD: begin
        if (idx_r == occ_r) begin
          base_nxt = idx_r;
          state_nxt = S_RA_RD;
        end else begin
          state_nxt = S_TCK_CHK;
        end
      end
      S_TCK_CHK: begin
        if (alu.a_le_b) begin
          idx_nxt = idx_inc[CW-1:0];
          state_nxt = S_TCK_RD;
        end else begin
          base_nxt = idx_r;
          state_nxt = S_RA_RD;
        end
      end

      // Re-arm decision from the new head entry.
      S_RA_RD: begin
        raddr = base_r[AW-1:0];
        if (remain == '0) begin
          if (armed_r) begin
            armed_nxt = 1'b0;
            act_nxt = ARM_CLEAR;
          end
          idx_nxt = '0;
          state_nxt = ((op_r == OP_TICK) && (base_r != '0)) ? S_EM_RD : S_OUT;
        end else begin
          state_nxt = S_RA_CHK;
        end
      end
      S_RA_CHK: begin
        if (!(armed_r && (armed_dl_r == rdata.deadline))) begin
          act_nxt = ARM_SET;
          gap_nxt = alu.gap;
          armed_dl_nxt = rdata.deadline;
          armed_nxt = 1'b1;
        end
        idx_nxt = '0;
        state_nxt = ((op_r == OP_TICK) && (base_r != '0)) ? S_EM_RD : S_OUT;
      end

      // Single reply word for insert, cancel and an empty tick.
      S_OUT: begin
        ov_nxt = 1'b1;
        ok_nxt = (op_r == OP_INSERT) ? KIND_INSERT :
                 (op_r == OP_CANCEL) ? KIND_CANCEL : KIND_IDLE_TICK;
        oid_nxt = (op_r == OP_TICK) ? '0 : id_r;
        ost_nxt = st_r;
        olast_nxt = 1'b1;
        oact_nxt = act_r;
        odur_nxt = gap_r;
        ocnt_nxt = occ_r;
        state_nxt = S_IDLE;
      end

      // Send expired entries in order.
      S_EM_RD: state_nxt = S_EM_OUT;
      S_EM_OUT: begin
        ov_nxt = 1'b1;
        ok_nxt = KIND_EXPIRED;
        oid_nxt = rdata.ident;
        ost_nxt = ST_OK;
        olast_nxt = (idx_inc == {1'b0, base_r});
        oact_nxt = olast_nxt ? act_r : ARM_LEAVE;
        odur_nxt = olast_nxt ? gap_r : '0;
        ocnt_nxt = remain;
        idx_nxt = olast_nxt ? '0 : idx_inc[CW-1:0];
        state_nxt = olast_nxt ? S_CMP_RD : S_EM_RD;
      end

      // Move the survivors down over the expired prefix.
      S_CMP_RD: begin
        raddr = AW'(sum_ib[CW-1:0]);
        if (sum_ib >= {1'b0, occ_r}) begin
          occ_nxt = remain;
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_CMP_WR;
        end
      end
      S_CMP_WR: begin
        we = 1'b1;
        idx_nxt = idx_inc[CW-1:0];
        state_nxt = S_CMP_RD;
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      occ_r <= '0;
      armed_r <= 1'b0;
      armed_dl_r <= '0;
      stopped_r <= 1'b0;
      ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      occ_r <= occ_nxt;
      armed_r <= armed_nxt;
      armed_dl_r <= armed_dl_nxt;
      stopped_r <= stopped_nxt;
      ov_r <= ov_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    base_r <= base_nxt;
    op_r <= op_nxt;
    id_r <= id_nxt;
    dur_in_r <= dur_in_nxt;
    now_r <= now_nxt;
    dl_r <= dl_nxt;
    st_r <= st_nxt;
    act_r <= act_nxt;
    gap_r <= gap_nxt;
    ok_r <= ok_nxt;
    oid_r <= oid_nxt;
    ost_r <= ost_nxt;
    olast_r <= olast_nxt;
    oact_r <= oact_nxt;
    odur_r <= odur_nxt;
    ocnt_r <= ocnt_nxt;
  end

  assign out_valid = ov_r;
  assign out_kind = ok_r;
  assign out_entry_id_out = oid_r;
  assign out_status = ost_r;
  assign out_last = olast_r;
  assign out_arm_action = oact_r;
  assign out_arm_duration = odur_r;
  assign out_pending_count = 6'(ocnt_r);

endmodule

/* dv/dtq_checker.sv */
// Checker for the deadline timer queue: watches both channels, predicts and compares.
module dtq_checker
  import dtq_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              busy,
  input  logic [1:0]        in_op,
  input  logic [ID_W-1:0]   in_entry_id,
  input  logic [TIME_W-1:0] in_duration,
  input  logic [TIME_W-1:0] in_now,
  input  logic              out_valid,
  input  logic [2:0]        out_kind,
  input  logic [ID_W-1:0]   out_entry_id_out,
  input  logic [1:0]        out_status,
  input  logic              out_last,
  input  logic [1:0]        out_arm_action,
  input  logic [TIME_W-1:0] out_arm_duration,
  input  logic [5:0]        out_pending_count,
  output int                fail_count,
  output int                words_pending
);

  typedef struct packed {
    logic [2:0]        kind;
    logic [ID_W-1:0]   ident;
    logic [1:0]        status;
    logic              last;
    logic [1:0]        arm;
    logic [TIME_W-1:0] arm_dur;
    logic [5:0]        pending;
  } reply_t;

  // Predicted timer store, kept sorted by deadline.
  logic [TIME_W-1:0] sched_dl [CAPACITY_DEF];
  logic [ID_W-1:0]   sched_id [CAPACITY_DEF];
  int                sched_cnt;
  logic              armed;
  logic [TIME_W-1:0] armed_at;
  logic              halted;
  reply_t            replies_due[$];

  assign words_pending = replies_due.size();

  // Decides how the one-shot timer is re-armed after the store changed.
  function automatic void rearm_decide(input logic [TIME_W-1:0] now,
                                       output logic [1:0] act,
                                       output logic [TIME_W-1:0] dur);
    act = ARM_LEAVE;
    dur = '0;
    if (sched_cnt == 0) begin
      if (armed) begin
        armed = 1'b0;
        act = ARM_CLEAR;
      end
    end else if (!(armed && armed_at == sched_dl[0])) begin
      dur = (sched_dl[0] > now) ? sched_dl[0] - now : 48'd1;
      armed_at = sched_dl[0];
      armed = 1'b1;
      act = ARM_SET;
    end
  endfunction

  function automatic void drop_entry(input int pos);
    for (int i = pos; i + 1 < sched_cnt; i++) begin
      sched_dl[i] = sched_dl[i+1];
      sched_id[i] = sched_id[i+1];
    end
    sched_cnt--;
  endfunction

  // Works out every reply word that one accepted command causes.
  function automatic void predict_replies(input logic [1:0] op, input logic [ID_W-1:0] id,
                                          input logic [TIME_W-1:0] dur_in,
                                          input logic [TIME_W-1:0] now);
    reply_t            words[$];
    reply_t            w;
    logic [1:0]        act;
    logic [TIME_W-1:0] dur;
    logic [TIME_W:0]   sum;
    int                pos;
    act = ARM_LEAVE;
    dur = '0;
    w = '0;
    case (op)
      OP_INSERT: begin
        w.kind = KIND_INSERT;
        w.ident = id;
        if (halted) begin
          w.status = ST_STOPPED;
        end else if (sched_cnt >= CAPACITY_DEF) begin
          w.status = ST_FULL;
        end else begin
          sum = {1'b0, now} + {1'b0, dur_in};
          if (sum[TIME_W]) sum = {1'b0, TIME_MAX};
          pos = 0;
          while (pos < sched_cnt && sched_dl[pos] <= sum[TIME_W-1:0]) pos++;
          for (int i = sched_cnt; i > pos; i--) begin
            sched_dl[i] = sched_dl[i-1];
            sched_id[i] = sched_id[i-1];
          end
          sched_dl[pos] = sum[TIME_W-1:0];
          sched_id[pos] = id;
          sched_cnt++;
          rearm_decide(now, act, dur);
        end
        words = {words, w};
      end
      OP_CANCEL: begin
        w.kind = KIND_CANCEL;
        w.ident = id;
        pos = 0;
        while (pos < sched_cnt && sched_id[pos] != id) pos++;
        if (pos < sched_cnt) begin
          drop_entry(pos);
          rearm_decide(now, act, dur);
        end else begin
          w.status = ST_NOT_FOUND;
        end
        words = {words, w};
      end
      OP_TICK: begin
        armed = 1'b0;
        while (sched_cnt > 0 && sched_dl[0] <= now) begin
          w = '0;
          w.kind = KIND_EXPIRED;
          w.ident = sched_id[0];
          words = {words, w};
          drop_entry(0);
        end
        rearm_decide(now, act, dur);
        if (words.size() == 0) begin
          w = '0;
          w.kind = KIND_IDLE_TICK;
          words = {words, w};
        end
      end
      default: begin
        sched_cnt = 0;
        halted = 1'b1;
        act = armed ? ARM_CLEAR : ARM_LEAVE;
        armed = 1'b0;
        w.kind = KIND_SHUTDOWN;
        words = {words, w};
      end
    endcase
    foreach (words[k]) begin
      words[k].pending = 6'(sched_cnt);
      if (k == words.size() - 1) begin
        words[k].last = 1'b1;
        words[k].arm = act;
        words[k].arm_dur = dur;
      end
      replies_due = {replies_due, words[k]};
    end
  endfunction

  // Compares one reply word with the oldest expected one.
  task automatic check_word();
    reply_t e;
    if (replies_due.size() == 0) begin
      $error("unexpected word: kind %0d id %0d", out_kind, out_entry_id_out);
      fail_count++;
      return;
    end
    e = replies_due.pop_front();
    if (out_kind !== e.kind) begin
      $error("kind: expected %0d, got %0d", e.kind, out_kind); fail_count++;
    end
    if (out_entry_id_out !== e.ident) begin
      $error("entry_id_out: expected %0d, got %0d", e.ident, out_entry_id_out); fail_count++;
    end
    if (out_status !== e.status) begin
      $error("status: expected %0d, got %0d", e.status, out_status); fail_count++;
    end
    if (out_last !== e.last) begin
      $error("last: expected %0d, got %0d", e.last, out_last); fail_count++;
    end
    if (out_arm_action !== e.arm) begin
      $error("arm_action: expected %0d, got %0d", e.arm, out_arm_action); fail_count++;
    end
    if (out_arm_duration !== e.arm_dur) begin
      $error("arm_duration: expected %0d, got %0d", e.arm_dur, out_arm_duration);
      fail_count++;
    end
    if (out_pending_count !== e.pending) begin
      $error("pending_count: expected %0d, got %0d", e.pending, out_pending_count);
      fail_count++;
    end
  endtask

  initial begin
    fail_count = 0;
    sched_cnt = 0;
    armed = 1'b0;
    armed_at = '0;
    halted = 1'b0;
  end

  // Sample both channels at each rising edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) check_word();
      if (start && !busy) predict_replies(in_op, in_entry_id, in_duration, in_now);
    end
  end

endmodule

/* dv/testbench.sv */
// Top of the deadline timer queue testbench: clock, reset, commands and verdict.
module testbench;
  import dtq_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  logic [1:0]        in_op;
  logic [ID_W-1:0]   in_entry_id;
  logic [TIME_W-1:0] in_duration;
  logic [TIME_W-1:0] in_now;
  logic              out_valid;
  logic [2:0]        out_kind;
  logic [ID_W-1:0]   out_entry_id_out;
  logic [1:0]        out_status;
  logic              out_last;
  logic [1:0]        out_arm_action;
  logic [TIME_W-1:0] out_arm_duration;
  logic [5:0]        out_pending_count;
  int                fail_count;
  int                words_pending;
  int                cycle_count;
  int                idle_pct;
  logic [TIME_W-1:0] clock_ms;

  deadline_timer_queue u_top (.*);

  dtq_checker u_checker (.*);

  always begin
    clk = 1'b0; #1;
    clk = 1'b1; #1;
  end

  // Watchdog on total run length.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL deadline_timer_queue");
      $finish;
    end
  end

  // Sends one command word and holds it until the block takes it. Start stays
  // high after the accepting edge; the next call either drops it for idle
  // cycles or replaces the word at once.
  task automatic send_cmd(input logic [1:0] op, input logic [ID_W-1:0] id,
                          input logic [TIME_W-1:0] dur, input logic [TIME_W-1:0] now);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < idle_pct) @(posedge clk);
    end
    start <= 1'b1;
    in_op <= op;
    in_entry_id <= id;
    in_duration <= dur;
    in_now <= now;
    do @(posedge clk); while (busy);
  endtask

  // Random time value: mostly small steps, sometimes anywhere.
  function automatic logic [TIME_W-1:0] rand_dur();
    case ($urandom_range(9))
      0: return TIME_W'({$urandom, $urandom});
      1: return TIME_MAX - $urandom_range(3);
      2: return '0;
      default: return TIME_W'($urandom_range(200));
    endcase
  endfunction

  // One random command against a slowly advancing clock.
  task automatic random_cmd(input int tag);
    int          r;
    logic [1:0]  op;
    r = $urandom_range(99);
    op = (r < 50) ? OP_INSERT : (r < 72) ? OP_CANCEL : (r < 99) ? OP_TICK : OP_SHUTDOWN;
    if (tag % 100 == 0) begin
      op = OP_TICK;
      clock_ms = TIME_MAX;
    end else if ($urandom_range(3) == 0) begin
      clock_ms = clock_ms + $urandom_range(60);
    end
    if ($urandom_range(15) == 0) clock_ms = TIME_W'({$urandom, $urandom});
    send_cmd(op, ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(40)),
             rand_dur(), clock_ms);
  endtask

  initial begin
    cycle_count = 0;
    idle_pct = 0;
    rst_n = 1'b0;
    start = 1'b0;
    in_op = OP_INSERT;
    in_entry_id = '0;
    in_duration = '0;
    in_now = '0;
    clock_ms = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: edges of fields, not-found cancel, idle tick, saturation, full store.
    send_cmd(OP_TICK, 8'd0, '0, '0);
    send_cmd(OP_CANCEL, 8'd7, '0, 48'd5);
    send_cmd(OP_INSERT, 8'hFF, TIME_MAX, TIME_MAX);
    send_cmd(OP_INSERT, 8'h00, '0, 48'd10);
    send_cmd(OP_INSERT, 8'h55, 48'd5, 48'd10);
    send_cmd(OP_INSERT, 8'hAA, 48'd5, 48'd10);
    send_cmd(OP_TICK, 8'd0, '0, 48'd12);
    send_cmd(OP_TICK, 8'd0, '0, 48'd15);
    send_cmd(OP_CANCEL, 8'hFF, '0, 48'd16);
    for (int i = 0; i < 33; i++) send_cmd(OP_INSERT, 8'(i), 48'(i % 5), 48'd20);
    send_cmd(OP_TICK, 8'd0, '0, TIME_MAX);

    // Random phases: sender idles 31%, then 65%, then not at all.
    for (int ph = 0; ph < 3; ph++) begin
      idle_pct = (ph == 0) ? 31 : (ph == 1) ? 65 : 0;
      for (int n = 0; n < 160; n++) random_cmd(n + ph * 160 + 1);
    end
    // Shutdown and insert after it to reach the stopped state.
    send_cmd(OP_SHUTDOWN, 8'd0, '0, clock_ms);
    send_cmd(OP_INSERT, 8'd3, 48'd1, clock_ms);
    send_cmd(OP_TICK, 8'd0, '0, clock_ms);
    send_cmd(OP_SHUTDOWN, 8'd0, '0, clock_ms);
    start <= 1'b0;

    while (words_pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fail_count == 0 && words_pending == 0) begin
      $display("PASS deadline_timer_queue");
    end else begin
      $display("FAIL deadline_timer_queue");
    end
    $finish;
  end

endmodule

/* deadline_timer_queue.f */
src/dtq_pkg.sv
src/dtq_ram.sv
src/dtq_alu.sv
src/deadline_timer_queue.sv
dv/dtq_checker.sv
dv/testbench.sv
